### hdl/cbts_pkg.sv
// Shared types, constants and codes of the burst task scheduler.
package cbts_pkg;

	localparam int MaxTasks  = 16;
	localparam int TimeWidth = 32;
	localparam int IdxW      = $clog2(MaxTasks);
	localparam int CntW      = $clog2(MaxTasks + 1);
	localparam int InW       = 67;
	localparam int OutW      = 201;
	localparam logic [TimeWidth-1:0] TMax = {TimeWidth{1'b1}};

	localparam logic [1:0] REQ_APPEND   = 2'd0;
	localparam logic [1:0] REQ_DISPATCH = 2'd1;
	localparam logic [1:0] REQ_CLEAR    = 2'd2;

	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_SJF  = 2'd1;
	localparam logic [1:0] MODE_PRIO = 2'd2;
	localparam logic [1:0] MODE_RR   = 2'd3;

	localparam logic [2:0] ST_SLICE   = 3'd0;
	localparam logic [2:0] ST_STORED  = 3'd1;
	localparam logic [2:0] ST_REFUSED = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	localparam logic [0:0] CFG_MODE    = 1'd0;
	localparam logic [0:0] CFG_QUANTUM = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN1, S_CHK1, S_MINSCAN, S_SCAN2, S_RUN,
		S_CALC, S_FINISH, S_COLLECT, S_PUSHSELF, S_OUT
	} cbts_state_t;

	// Scan kinds performed by the datapath
	typedef enum logic [1:0] {
		SCAN_COLLECT, SCAN_MIN, SCAN_BEST
	} cbts_scan_t;

	typedef struct packed {
		logic        scan_start;
		cbts_scan_t  scan_kind;
		logic        use_end;     // collect at slice end instead of sim time
		logic        skip_run;    // exclude running task from collect
		logic        do_append;
		logic        do_clear;
		logic        do_run;      // pop ring or take best pick, then run it
		logic        do_calc;
		logic        do_finish;
		logic        do_pushself;
		logic        set_min;
		logic        load_res;
		logic [2:0]  res_status;
	} cbts_cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic any_left;
		logic ring_empty;
		logic best_none;
		logic full_or_begun;
		logic remain_left;
	} cbts_stat_t;

	function automatic logic [TimeWidth-1:0] sat_add(
		input logic [TimeWidth-1:0] a, input logic [TimeWidth-1:0] b);
		logic [TimeWidth:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeWidth] ? TMax : s[TimeWidth-1:0];
	endfunction

endpackage

### hdl/cbts_ctrl.sv
// Request sequencer of the burst task scheduler.
module cbts_ctrl import cbts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [1:0] req,
	input  logic [1:0] mode,
	input  logic       out_busy,
	input  cbts_stat_t st,
	output cbts_cmd_t  cmd,
	output logic       idle
);
	cbts_state_t state_q, state_d;
	logic [1:0] req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= REQ_APPEND;
		end else begin
			state_q <= state_d;
			if (in_fire) req_q <= req;
		end
	end

	logic ring_mode;
	assign ring_mode = (mode == MODE_FCFS) || (mode == MODE_RR);
	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_kind = SCAN_COLLECT;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_DECODE;
			S_DECODE: begin
				unique case (req_q)
					REQ_APPEND: begin
						cmd.do_append = !st.full_or_begun;
						cmd.res_status = st.full_or_begun ? ST_REFUSED : ST_STORED;
						state_d = S_OUT;
					end
					REQ_CLEAR: begin
						cmd.do_clear = 1'b1;
						cmd.res_status = ST_CLEARED;
						state_d = S_OUT;
					end
					REQ_DISPATCH: begin
						if (!st.any_left) begin
							cmd.res_status = ST_EMPTY;
							state_d = S_OUT;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.scan_kind = (ring_mode && !st.ring_empty) ? SCAN_COLLECT
								: (ring_mode ? SCAN_COLLECT : SCAN_BEST);
							state_d = (ring_mode && !st.ring_empty) ? S_RUN : S_SCAN1;
							if (ring_mode && !st.ring_empty) cmd.scan_start = 1'b0;
						end
					end
					default: begin
						cmd.res_status = ST_REFUSED;
						state_d = S_OUT;
					end
				endcase
				cmd.load_res = (state_d == S_OUT);
			end
			S_SCAN1: if (!st.scan_busy) state_d = S_CHK1;
			S_CHK1: begin
				if ((ring_mode && st.ring_empty) || (!ring_mode && st.best_none)) begin
					cmd.scan_start = 1'b1;
					cmd.scan_kind = SCAN_MIN;
					state_d = S_MINSCAN;
				end else state_d = S_RUN;
			end
			S_MINSCAN: if (!st.scan_busy) begin
				cmd.set_min = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_kind = ring_mode ? SCAN_COLLECT : SCAN_BEST;
				state_d = S_SCAN2;
			end
			S_SCAN2: if (!st.scan_busy) state_d = S_RUN;
			S_RUN: begin
				cmd.do_run = 1'b1;
				state_d = S_CALC;
			end
			S_CALC: begin
				cmd.do_calc = 1'b1;
				if (mode == MODE_RR) begin
					cmd.scan_start = 1'b1;
					cmd.scan_kind = SCAN_COLLECT;
					cmd.use_end = 1'b1;
					cmd.skip_run = 1'b1;
					state_d = S_COLLECT;
				end else state_d = S_FINISH;
			end
			S_COLLECT: begin
				cmd.use_end = 1'b1;
				cmd.skip_run = 1'b1;
				if (!st.scan_busy) state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.do_finish = 1'b1;
				cmd.do_pushself = st.remain_left;
				if (!st.remain_left && mode == MODE_FCFS) begin
					cmd.scan_start = 1'b1;
					cmd.use_end = 1'b1;
					state_d = S_PUSHSELF;
				end else begin
					cmd.load_res = 1'b1;
					cmd.res_status = ST_SLICE;
					state_d = S_OUT;
				end
			end
			S_PUSHSELF: begin
				cmd.use_end = 1'b1;
				if (!st.scan_busy) begin
					cmd.load_res = 1'b1;
					cmd.res_status = ST_SLICE;
					state_d = S_OUT;
				end
			end
			S_OUT: if (!out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### hdl/cbts_dpath.sv
// Task table, ready ring, scan unit and slice arithmetic.
module cbts_dpath import cbts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [InW-1:0]       in_data,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [15:0]          cfg_val,
	input  cbts_cmd_t            cmd,
	output cbts_stat_t           st,
	output logic [1:0]           mode,
	output logic [OutW-1:0]      res
);
	logic [1:0]  mode_q;
	logic [15:0] quant_q;
	logic [InW-1:0] in_q;

	logic [15:0] arr_q [MaxTasks];
	logic [7:0]  prio_q [MaxTasks];
	logic [7:0]  loops_q [MaxTasks];
	logic [15:0] cpu_q [MaxTasks];
	logic [15:0] io_q [MaxTasks];
	logic        trail_q [MaxTasks];
	logic [7:0]  lidx_q [MaxTasks];
	logic [15:0] rem_q [MaxTasks];
	logic [TimeWidth-1:0] rdy_q [MaxTasks];
	logic [TimeWidth-1:0] first_q [MaxTasks];
	logic [MaxTasks-1:0] ran_q, done_q, queued_q;
	logic [IdxW-1:0] ring_q [MaxTasks];
	logic [IdxW-1:0] head_q, tail_q;
	logic [CntW-1:0] count_q, total_q;
	logic [TimeWidth-1:0] time_q;
	logic begun_q;

	// scan unit
	logic scan_busy_q;
	cbts_scan_t kind_q;
	logic [IdxW-1:0] sidx_q;
	logic [TimeWidth-1:0] min_q;
	logic [IdxW-1:0] best_q;
	logic best_none_q;

	// slice registers
	logic [IdxW-1:0] run_q;
	logic [TimeWidth-1:0] start_q, end_q;
	logic complete_q;
	logic [TimeWidth-1:0] ewio_q, busy_q;
	logic [OutW-1:0] res_q, res_d;

	logic [15:0] f_arr, f_cpu, f_io;
	logic [7:0]  f_loops, f_prio;
	logic        f_trail;
	assign f_arr   = in_q[17:2];
	assign f_loops = in_q[25:18];
	assign f_cpu   = in_q[41:26];
	assign f_io    = in_q[57:42];
	assign f_trail = in_q[58];
	assign f_prio  = in_q[66:59];

	logic [TimeWidth-1:0] tref;
	assign tref = cmd.use_end ? end_q : time_q;

	logic s_valid, s_ready, s_take, s_better, s_last;
	logic [IdxW-1:0] pk;
	logic [15:0] ki, kb;
	assign s_valid = ({1'b0, sidx_q} < total_q);
	assign s_ready = s_valid && !done_q[sidx_q] && (rdy_q[sidx_q] <= tref);
	assign s_last  = (sidx_q == IdxW'(MaxTasks - 1)) || !({1'b0, sidx_q} + 1'b1 < total_q);
	assign s_take  = s_ready && !queued_q[sidx_q] && !(cmd.skip_run && sidx_q == run_q);
	assign ki = (mode_q == MODE_PRIO) ? {8'd0, prio_q[sidx_q]} : rem_q[sidx_q];
	assign kb = (mode_q == MODE_PRIO) ? {8'd0, prio_q[best_q]} : rem_q[best_q];
	assign s_better = best_none_q || ki < kb || (ki == kb && arr_q[sidx_q] < arr_q[best_q]);

	logic anyl;
	assign anyl = |(~done_q & ((MaxTasks)'(1) << total_q) - 1'b1)
		|| (total_q == CntW'(MaxTasks) && ~&done_q);

	logic [TimeWidth-1:0] tr, turn_w;
	logic [15:0] qn, rl;
	assign qn = (quant_q == 16'd0) ? 16'd1 : quant_q;
	assign pk = (mode_q == MODE_FCFS || mode_q == MODE_RR) ? ring_q[head_q]
		: (best_none_q ? '0 : best_q);
	assign rl = (mode_q == MODE_RR && qn < rem_q[pk]) ? qn : rem_q[pk];
	assign tr = trail_q[run_q] ? TimeWidth'(io_q[run_q]) : '0;
	assign turn_w = ewio_q - TimeWidth'(arr_q[run_q]);

	assign st.scan_busy = scan_busy_q;
	assign st.any_left = anyl;
	assign st.ring_empty = (count_q == '0);
	assign st.best_none = best_none_q;
	assign st.full_or_begun = begun_q || (total_q >= CntW'(MaxTasks));
	assign st.remain_left = (rem_q[run_q] != 16'd0);
	assign mode = mode_q;
	assign res = res_q;

	always_comb begin
		res_d = '0;
		res_d[2:0] = cmd.res_status;
		if (cmd.res_status == ST_STORED) res_d[7:3] = 5'(total_q + 1'b1);
		if (cmd.res_status == ST_SLICE) begin
			res_d[7:3] = 5'(run_q) + 5'd1;
			res_d[39:8] = 32'(start_q);
			res_d[71:40] = 32'(end_q);
			res_d[72] = complete_q;
			if (complete_q) begin
				res_d[104:73] = 32'(first_q[run_q]);
				res_d[136:105] = 32'(ewio_q);
				res_d[168:137] = 32'(turn_w);
				res_d[200:169] = (turn_w > busy_q) ? 32'(turn_w - busy_q) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) in_q <= in_data;
		if (cmd.do_run) begin
			run_q <= pk;
			start_q <= time_q;
			end_q <= sat_add(time_q, TimeWidth'(rl));
		end
		if (cmd.do_calc) begin
			ewio_q <= sat_add(end_q, tr);
			busy_q <= TimeWidth'(loops_q[run_q]) * TimeWidth'(cpu_q[run_q]) + tr
				+ TimeWidth'(loops_q[run_q] - 8'd1) * TimeWidth'(io_q[run_q]);
			complete_q <= (rem_q[run_q] == 16'd0) && (lidx_q[run_q] + 8'd1 >= loops_q[run_q]);
		end
		if (cmd.load_res) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS; quant_q <= 16'd1;
			ran_q <= '0; done_q <= '0; queued_q <= '0;
			head_q <= '0; tail_q <= '0; count_q <= '0; total_q <= '0;
			time_q <= '0; begun_q <= 1'b0; scan_busy_q <= 1'b0;
			kind_q <= SCAN_COLLECT; sidx_q <= '0; best_none_q <= 1'b1;
			for (int k = 0; k < MaxTasks; k++) lidx_q[k] <= '0;
		end else begin
			if (cfg_we && cfg_idx == CFG_MODE) begin
				mode_q <= cfg_val[1:0];
				queued_q <= '0; head_q <= '0; tail_q <= '0; count_q <= '0;
			end
			if (cfg_we && cfg_idx == CFG_QUANTUM) quant_q <= cfg_val;
			if (cmd.do_clear) begin
				ran_q <= '0; done_q <= '0; queued_q <= '0;
				head_q <= '0; tail_q <= '0; count_q <= '0; total_q <= '0;
				time_q <= '0; begun_q <= 1'b0;
				for (int k = 0; k < MaxTasks; k++) lidx_q[k] <= '0;
			end
			if (cmd.do_append) begin
				arr_q[total_q[IdxW-1:0]] <= f_arr;
				loops_q[total_q[IdxW-1:0]] <= (f_loops == 8'd0) ? 8'd1 : f_loops;
				cpu_q[total_q[IdxW-1:0]] <= (f_cpu == 16'd0) ? 16'd1 : f_cpu;
				io_q[total_q[IdxW-1:0]] <= f_io;
				trail_q[total_q[IdxW-1:0]] <= (f_loops == 8'd0) ? (f_io != 16'd0) : f_trail;
				prio_q[total_q[IdxW-1:0]] <= f_prio;
				lidx_q[total_q[IdxW-1:0]] <= '0;
				rem_q[total_q[IdxW-1:0]] <= (f_cpu == 16'd0) ? 16'd1 : f_cpu;
				rdy_q[total_q[IdxW-1:0]] <= TimeWidth'(f_arr);
				ran_q[total_q[IdxW-1:0]] <= 1'b0;
				done_q[total_q[IdxW-1:0]] <= 1'b0;
				queued_q[total_q[IdxW-1:0]] <= 1'b0;
				total_q <= total_q + 1'b1;
			end
			if (cmd.set_min) time_q <= min_q;
			if (cmd.scan_start) begin
				scan_busy_q <= 1'b1; kind_q <= cmd.scan_kind; sidx_q <= '0;
				min_q <= TMax; best_none_q <= 1'b1;
			end else if (scan_busy_q) begin
				if (total_q == '0) scan_busy_q <= 1'b0;
				else begin
					unique case (kind_q)
						SCAN_COLLECT: if (s_take && count_q < CntW'(MaxTasks)) begin
							ring_q[tail_q] <= sidx_q;
							tail_q <= (tail_q == IdxW'(MaxTasks - 1)) ? '0 : tail_q + 1'b1;
							count_q <= count_q + 1'b1;
							queued_q[sidx_q] <= 1'b1;
						end
						SCAN_MIN: if (s_valid && !done_q[sidx_q] && rdy_q[sidx_q] < min_q)
							min_q <= rdy_q[sidx_q];
						SCAN_BEST: if (s_ready && s_better) begin
							best_q <= sidx_q; best_none_q <= 1'b0;
						end
						default: ;
					endcase
					if (s_last) scan_busy_q <= 1'b0;
					else sidx_q <= sidx_q + 1'b1;
				end
			end
			if (cmd.do_run) begin
				begun_q <= 1'b1;
				if (mode_q == MODE_FCFS || mode_q == MODE_RR) begin
					head_q <= (head_q == IdxW'(MaxTasks - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
					queued_q[pk] <= 1'b0;
				end
				if (!ran_q[pk]) begin
					ran_q[pk] <= 1'b1; first_q[pk] <= time_q;
				end
				rem_q[pk] <= rem_q[pk] - rl;
				time_q <= sat_add(time_q, TimeWidth'(rl));
			end
			if (cmd.do_finish) begin
				if (cmd.do_pushself) begin
					if (count_q < CntW'(MaxTasks)) begin
						ring_q[tail_q] <= run_q;
						tail_q <= (tail_q == IdxW'(MaxTasks - 1)) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
						queued_q[run_q] <= 1'b1;
					end
				end else begin
					lidx_q[run_q] <= lidx_q[run_q] + 8'd1;
					if (complete_q) done_q[run_q] <= 1'b1;
					else begin
						rdy_q[run_q] <= sat_add(end_q, TimeWidth'(io_q[run_q]));
						rem_q[run_q] <= cpu_q[run_q];
					end
				end
			end
		end
	end
endmodule

### hdl/cpu_burst_task_scheduler_core.sv
// Top level of the CPU burst task scheduler.
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       request and task record
//   m_axis    out  m_axis_tvalid/tready       slice or status result
//   cfg       in   cfg_we                     sched_mode, time_quantum
// Append, clear and refused requests have their result registered from the decode state.
// A dispatch runs up to four table scans (one entry a cycle) before its result is loaded.
// The result waits in the output register; the next request is taken once it is
// delivered. arst_n clears all control state; table payload is written on append.
module cpu_burst_task_scheduler_core import cbts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// req_type[1:0], arrival_time[17:2], loop_count[25:18], cpu_time[41:26],
	// io_time[57:42], trail_io_en[58], priority_level[66:59], zero fill
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], task_id[7:3], slice_start[39:8], slice_end[71:40],
	// task_complete[72], first_run_time[104:73], io_end_time[136:105],
	// turnaround[168:137], waiting[200:169], zero fill
	output logic [207:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);
	cbts_cmd_t  cmd;
	cbts_stat_t st;
	logic idle, in_fire, out_q;
	logic [1:0] mode;
	logic [OutW-1:0] res;

	assign s_axis_tready = idle && !out_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= 1'b0;
		else if (cmd.load_res) out_q <= 1'b1;
		else if (m_axis_tready) out_q <= 1'b0;
	end
	assign m_axis_tvalid = out_q;
	assign m_axis_tdata = {7'd0, res};

	cbts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .req(s_axis_tdata[1:0]),
		.mode(mode), .out_busy(out_q), .st(st), .cmd(cmd), .idle(idle)
	);

	cbts_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_data(s_axis_tdata[InW-1:0]),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_val(cfg_data),
		.cmd(cmd), .st(st), .mode(mode), .res(res)
	);
endmodule
